/* sv/sdv_pkg.sv */
// shared types and constants for the sample-stuffing dithered volume block
package sdv_pkg;

  localparam int unsigned MAX_FRAME_LENGTH = 4096;
  localparam int unsigned FRAME_W          = 13;
  localparam int unsigned INDEX_W          = 12;
  localparam int unsigned GAIN_W           = 17;
  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned CFG_INDEX_W      = 1;
  localparam int unsigned CFG_DATA_W       = 17;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QUEUE_AW         = 2;

  localparam logic [FRAME_W-1:0]  FRAME_RESET = 13'd352;
  localparam logic [GAIN_W-1:0]   GAIN_UNITY  = 17'h10000;
  localparam logic [31:0]         LCG_SEED    = 32'd12345;
  localparam logic [31:0]         LCG_MULT    = 32'd69069;
  localparam logic [31:0]         LCG_INC     = 32'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_GAIN  = 1'd1;

  // stuffing modes
  localparam logic [1:0] STUFF_NONE   = 2'd0;
  localparam logic [1:0] STUFF_INSERT = 2'd1;
  localparam logic [1:0] STUFF_DROP   = 2'd2;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         stuff_mode;
    logic [11:0]        stuff_position;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_of_item;
  } out_item_t;

  // one pair waiting to be scaled
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_req_t;

endpackage

/* sv/sdv_front.sv */
// front end: frame position tracking, stuffing decision and pair averaging
module sdv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sdv_pkg::in_item_t              in_data,
  input  logic [sdv_pkg::FRAME_W-1:0]    frame_length,
  input  logic                           queue_full,
  output sdv_pkg::push_req_t             push_req
);
  import sdv_pkg::*;

  logic [INDEX_W-1:0]  pair_index;
  logic signed [15:0]  held_left;
  logic signed [15:0]  held_right;
  logic                need_avg;
  logic                need_cur;
  job_t                avg_job;
  job_t                cur_job;

  logic                accept;
  logic                here;
  logic [FRAME_W-1:0]  len;
  logic [FRAME_W-1:0]  index_inc;
  logic signed [16:0]  sum_left;
  logic signed [16:0]  sum_right;

  assign in_stall = need_avg | need_cur;
  assign accept   = in_valid & ~in_stall;
  assign here     = (pair_index == in_data.stuff_position);

  // clamp frame length to 1..MAX_FRAME_LENGTH
  always_comb begin
    if (frame_length == '0) begin
      len = FRAME_W'(1);
    end else if (frame_length > FRAME_W'(MAX_FRAME_LENGTH)) begin
      len = FRAME_W'(MAX_FRAME_LENGTH);
    end else begin
      len = frame_length;
    end
  end

  assign index_inc = {1'b0, pair_index} + FRAME_W'(1);

  // floor average with the held pair
  assign sum_left  = 17'(held_left) + 17'(in_data.left_sample);
  assign sum_right = 17'(held_right) + 17'(in_data.right_sample);

  // push the average first, then the current pair
  always_comb begin
    push_req.push = 1'b0;
    push_req.job  = cur_job;
    if (!queue_full) begin
      if (need_avg) begin
        push_req.push = 1'b1;
        push_req.job  = avg_job;
      end else if (need_cur) begin
        push_req.push = 1'b1;
      end
    end
  end

  // item capture and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_index <= '0;
      held_left  <= '0;
      held_right <= '0;
      need_avg   <= 1'b0;
      need_cur   <= 1'b0;
    end else begin
      if (accept) begin
        need_avg   <= here && (in_data.stuff_mode == STUFF_INSERT);
        need_cur   <= !(here && (in_data.stuff_mode == STUFF_DROP));
        held_left  <= in_data.left_sample;
        held_right <= in_data.right_sample;
        if (index_inc >= len) begin
          pair_index <= '0;
        end else begin
          pair_index <= index_inc[INDEX_W-1:0];
        end
      end else if (push_req.push) begin
        if (need_avg) begin
          need_avg <= 1'b0;
        end else begin
          need_cur <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      avg_job.left  <= sum_left[16:1];
      avg_job.right <= sum_right[16:1];
      avg_job.last  <= 1'b0;
      cur_job.left  <= in_data.left_sample;
      cur_job.right <= in_data.right_sample;
      cur_job.last  <= 1'b1;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push_req.push)
    else $error("front pushed into a full queue");

  a_avg_before_cur: assert property (@(posedge clk) disable iff (rst)
    need_avg |-> need_cur)
    else $error("average pending without its current pair");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> ({1'b0, pair_index} < len || len != $past(len)))
    else $error("pair index beyond frame");

endmodule

/* sv/sdv_queue.sv */
// short queue of pending pairs between the front and back ends
module sdv_queue (
  input  logic               clk,
  input  logic               rst,
  input  sdv_pkg::push_req_t push_req,
  input  logic               pop,
  output sdv_pkg::job_t      head,
  output logic               empty,
  output logic               full
);
  import sdv_pkg::*;

  job_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_req.push) begin
      mem[wr_ptr] <= push_req.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_req.push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push_req.push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push_req.push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push_req.push)
    else $error("push into full queue");

endmodule

/* sv/sdv_back.sv */
// back end: gain multiply, lcg dither and output register
module sdv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  sdv_pkg::job_t                head,
  input  logic                         empty,
  output logic                         pop,
  input  logic [sdv_pkg::GAIN_W-1:0]   volume_gain,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sdv_pkg::out_item_t           out_data
);
  import sdv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ML, S_AL, S_MR, S_AR
  } state_t;

  state_t              state;
  job_t                job;
  logic [31:0]         prod;
  logic [31:0]         lcg_state;
  logic [15:0]         dither_newest;
  logic [15:0]         dither_previous;
  logic signed [15:0]  res_left;

  logic                dither_on;
  logic [31:0]         lcg_next;
  logic signed [15:0]  mul_in;
  logic [31:0]         prod_full;
  logic [31:0]         acc;
  logic                out_free;

  assign dither_on = ~volume_gain[GAIN_W-1];
  assign lcg_next  = lcg_state * LCG_MULT + LCG_INC;
  assign mul_in    = (state == S_ML) ? job.left : job.right;
  assign prod_full = 32'(mul_in) * 32'($signed({1'b0, volume_gain}));
  assign out_free  = ~out_valid | ~out_stall;
  assign pop       = (state == S_IDLE) && !empty;

  // product, plus the dither difference when dither is on
  always_comb begin
    acc = prod;
    if (dither_on) begin
      acc = prod + {{16{dither_newest[15]}}, dither_newest}
                 - {{16{dither_previous[15]}}, dither_previous};
    end
  end

  // sequencer, dither state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      lcg_state       <= LCG_SEED;
      dither_newest   <= '0;
      dither_previous <= '0;
      out_valid       <= 1'b0;
    end else begin
      // load a new result or release the accepted one
      if (state == S_AR && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= S_ML;
          end
        end
        S_ML, S_MR: begin
          if (dither_on) begin
            lcg_state       <= lcg_next;
            dither_previous <= dither_newest;
            dither_newest   <= lcg_next[15:0];
          end
          state <= (state == S_ML) ? S_AL : S_AR;
        end
        S_AL: begin
          state <= S_MR;
        end
        S_AR: begin
          if (out_free) begin
            out_data.left_out     <= res_left;
            out_data.right_out    <= acc[31:16];
            out_data.last_of_item <= job.last;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (state == S_ML || state == S_MR) begin
      prod <= prod_full;
    end
    if (state == S_AL) begin
      res_left <= acc[31:16];
    end
  end

  a_lcg_only_dither: assert property (@(posedge clk) disable iff (rst)
    !$stable(lcg_state) |-> $past(dither_on))
    else $error("lcg advanced without dither");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("held result overwritten");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_ML)
    else $error("pop did not start a pair");

endmodule

/* sv/sample_stuff_dithered_volume.sv */
// top level of the sample-stuffing dithered volume block
// an accepted request is registered in the front end, pushed into the queue, then scaled by the back end
// the back end takes one pair at a time: pop, left multiply, left add, right multiply, right add
// one request gives one result, or two with an inserted pair (the average first); a dropped pair gives none
// the front end and the queue let new requests in while the back end works
// reset (rst, synchronous): frame length 352, unity gain, lcg seed 12345, state cleared
module sample_stuff_dithered_volume (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sdv_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sdv_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [sdv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sdv_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sdv_pkg::*;

  logic [FRAME_W-1:0]  frame_length;
  logic [GAIN_W-1:0]   volume_gain;
  push_req_t           push_req;
  job_t                head;
  logic                empty;
  logic                full;
  logic                pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_RESET;
      volume_gain  <= GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LENGTH: frame_length <= cfg_data[FRAME_W-1:0];
        CFG_VOLUME_GAIN:  volume_gain  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sdv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .frame_length (frame_length),
    .queue_full   (full),
    .push_req     (push_req)
  );

  sdv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  sdv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .volume_gain (volume_gain),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

/* sim/tb.sv */
// testbench for the sample-stuffing dithered volume block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdv_pkg::*;

  // stuff mode that the block treats like no stuffing
  localparam logic [1:0] STUFF_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sample_stuff_dithered_volume i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block's registers and state
  logic [FRAME_W-1:0] frame_len_reg = FRAME_RESET;
  logic [GAIN_W-1:0] gain_reg = GAIN_UNITY;
  logic [31:0] lcg = LCG_SEED;
  logic [15:0] dither_new = '0;
  logic [15:0] dither_old = '0;
  logic signed [15:0] held_left = '0;
  logic signed [15:0] held_right = '0;
  int unsigned frame_pos = 0;

  out_item_t pending_outputs[$];
  int mismatches = 0;
  int unsigned cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // current stuffing plan for the random frames
  logic [1:0] plan_mode = STUFF_NONE;
  logic [11:0] plan_pos = '0;

  // directed table
  typedef struct {
    bit is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t req;
    int n_typed;
    out_item_t exp0;
    out_item_t exp1;
  } row_t;

  row_t directed[$];

  function automatic int unsigned frame_span();
    int unsigned len;
    len = 32'(frame_len_reg);
    if (len < 1) len = 1;
    if (len > MAX_FRAME_LENGTH) len = MAX_FRAME_LENGTH;
    return len;
  endfunction

  // gain multiply with lcg dither below unity, wraps to 16 bits
  function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s);
    longint acc;
    acc = longint'(s) * longint'(gain_reg);
    if (gain_reg < GAIN_UNITY) begin
      dither_old = dither_new;
      lcg = lcg * LCG_MULT + LCG_INC;
      dither_new = lcg[15:0];
      acc = acc + longint'($signed(dither_new)) - longint'($signed(dither_old));
    end
    return acc[31:16];
  endfunction

  // floor of the mean of two samples
  function automatic logic signed [15:0] midpoint(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    int sum;
    sum = int'(a) + int'(b);
    return 16'(sum >>> 1);
  endfunction

  // frame bookkeeping, stuffing and scaling for one accepted pair
  task automatic stuff_and_scale(input in_item_t req, output out_item_t res[2],
                                 output int n);
    int unsigned len;
    bit here;
    len = frame_span();
    here = (frame_pos == req.stuff_position);
    n = 0;
    if (!(here && req.stuff_mode == STUFF_DROP)) begin
      if (here && req.stuff_mode == STUFF_INSERT) begin
        res[0].left_out = scale_sample(midpoint(held_left, req.left_sample));
        res[0].right_out = scale_sample(midpoint(held_right, req.right_sample));
        res[0].last_of_item = 1'b0;
        n = 1;
      end
      res[n].left_out = scale_sample(req.left_sample);
      res[n].right_out = scale_sample(req.right_sample);
      res[n].last_of_item = 1'b1;
      n++;
    end
    held_left = req.left_sample;
    held_right = req.right_sample;
    frame_pos = (frame_pos + 1 >= len) ? 0 : frame_pos + 1;
  endtask

  // hand one request to the block, then record what it must produce
  task automatic send_request(input in_item_t req, input int n_typed,
                              input out_item_t typed0, input out_item_t typed1);
    out_item_t got[2];
    int n;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    stuff_and_scale(req, got, n);
    if (n_typed < 0) begin
      for (int i = 0; i < n; i++) pending_outputs.push_back(got[i]);
    end else begin
      if (n_typed > 0) pending_outputs.push_back(typed0);
      if (n_typed > 1) pending_outputs.push_back(typed1);
    end
  endtask

  // stop sending and let every expected output come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FRAME_LENGTH) frame_len_reg = val[FRAME_W-1:0];
    else gain_reg = val;
  endtask

  task automatic add_item(input int l, input int r, input logic [1:0] mode,
                          input int pos, input int n, input int al, input int ar,
                          input int bl, input int br);
    row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req.left_sample = 16'(l);
    row.req.right_sample = 16'(r);
    row.req.stuff_mode = mode;
    row.req.stuff_position = 12'(pos);
    row.n_typed = n;
    row.exp0.left_out = 16'(al);
    row.exp0.right_out = 16'(ar);
    row.exp0.last_of_item = (n == 1);
    row.exp1.left_out = 16'(bl);
    row.exp1.right_out = 16'(br);
    row.exp1.last_of_item = 1'b1;
    directed.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed.push_back(row);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly one stuffing plan per frame, some requests with random mode and position
  task automatic next_random_request(output in_item_t req);
    int unsigned roll;
    if (frame_pos == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) plan_mode = STUFF_INSERT;
      else if (roll < 70) plan_mode = STUFF_DROP;
      else if (roll < 85) plan_mode = STUFF_NONE;
      else plan_mode = STUFF_SPARE;
      if ($urandom_range(0, 99) < 85) plan_pos = 12'($urandom_range(0, frame_span() - 1));
      else plan_pos = 12'($urandom_range(0, 4095));
    end
    req.left_sample = pick_sample();
    req.right_sample = pick_sample();
    if ($urandom_range(0, 9) == 0) begin
      req.stuff_mode = 2'($urandom);
      req.stuff_position = 12'($urandom);
    end else begin
      req.stuff_mode = plan_mode;
      req.stuff_position = plan_pos;
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare each output with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output: left %0d right %0d last %0b",
                   out_data.left_out, out_data.right_out, out_data.last_of_item);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_data.left_out !== want.left_out || out_data.right_out !== want.right_out ||
            out_data.last_of_item !== want.last_of_item) begin
          if (mismatches < 10)
            $display("output mismatch: expected %0d %0d last %0b, got %0d %0d last %0b",
                     want.left_out, want.right_out, want.last_of_item,
                     out_data.left_out, out_data.right_out, out_data.last_of_item);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // per-phase settings of the random part
  int phase_frame [9] = '{5, 3, 12, 2, 0, 4096, 8191, 7, -1};
  int phase_gain [9] = '{65536, 40000, 65535, 98304, 0, 131071, 65536, 12345, -1};
  int phase_idle [9] = '{0, 48, 0, 28, 0, 48, 0, 28, 28};
  int phase_stall [9] = '{0, 0, 48, 28, 48, 0, 48, 28, 0};
  int phase_items [9] = '{150, 150, 150, 150, 100, 100, 100, 150, 100};

  initial begin
    in_item_t req;
    out_item_t blank;
    blank = '0;

    // reset values: frame 352, unity gain
    add_item(32767, -32768, STUFF_NONE, 5, 1, 32767, -32768, 0, 0);
    add_item(-32768, 32767, STUFF_INSERT, 1, 2, -1, -1, -32768, 32767);
    add_item(1234, -1234, STUFF_DROP, 2, 0, 0, 0, 0, 0);
    add_item(0, 0, STUFF_INSERT, 3, 2, 617, -617, 0, 0);
    add_item(100, -100, STUFF_SPARE, 4, 1, 100, -100, 0, 0);
    // position that the frame never reaches
    add_item(5, 6, STUFF_INSERT, 4095, 1, 5, 6, 0, 0);
    // one-pair frames: every pair is index zero, insert uses the held pair
    add_cfg(CFG_FRAME_LENGTH, 1);
    add_item(-7, 9, STUFF_NONE, 0, 1, -7, 9, 0, 0);
    add_item(32767, 32767, STUFF_INSERT, 0, 2, 16380, 16388, 32767, 32767);
    add_item(-32768, -32768, STUFF_DROP, 0, 0, 0, 0, 0, 0);
    add_item(-32768, -32768, STUFF_INSERT, 0, 2, -32768, -32768, -32768, -32768);
    add_cfg(CFG_FRAME_LENGTH, 0);
    add_item(1, -1, STUFF_INSERT, 0, 2, -16384, -16385, 1, -1);
    // largest gain, no dither
    add_cfg(CFG_VOLUME_GAIN, 131071);
    add_item(1, -1, STUFF_NONE, 5, 1, 1, -2, 0, 0);
    add_item(32767, -32768, STUFF_NONE, 0, -1, 0, 0, 0, 0);
    // zero gain leaves only the dither
    add_cfg(CFG_VOLUME_GAIN, 0);
    add_item(32767, -32768, STUFF_INSERT, 0, -1, 0, 0, 0, 0);
    add_item(-1, 1, STUFF_DROP, 0, -1, 0, 0, 0, 0);
    add_item(123, -456, STUFF_INSERT, 0, -1, 0, 0, 0, 0);
    // just below unity
    add_cfg(CFG_VOLUME_GAIN, 65535);
    add_item(32767, -32768, STUFF_NONE, 0, -1, 0, 0, 0, 0);
    add_item(-32768, 32767, STUFF_INSERT, 0, -1, 0, 0, 0, 0);
    // frame length above the maximum
    add_cfg(CFG_FRAME_LENGTH, 8191);
    add_cfg(CFG_VOLUME_GAIN, 32768);
    add_item(1000, -1000, STUFF_INSERT, 0, -1, 0, 0, 0, 0);
    add_item(-5, 5, STUFF_DROP, 1, -1, 0, 0, 0, 0);
    add_cfg(CFG_FRAME_LENGTH, 2);
    add_item(7, 8, STUFF_INSERT, 2, -1, 0, 0, 0, 0);
    add_item(9, 10, STUFF_DROP, 0, -1, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        wait_quiet();
        write_reg(directed[k].reg_idx, directed[k].reg_val);
      end else begin
        send_request(directed[k].req, directed[k].n_typed, directed[k].exp0,
                     directed[k].exp1);
      end
    end

    // random phases, registers rewritten only once the block has drained
    for (int p = 0; p < 9; p++) begin
      wait_quiet();
      write_reg(CFG_FRAME_LENGTH,
                CFG_DATA_W'((phase_frame[p] < 0) ? $urandom_range(2, 40) : phase_frame[p]));
      write_reg(CFG_VOLUME_GAIN,
                CFG_DATA_W'((phase_gain[p] < 0) ? $urandom_range(0, 131071) : phase_gain[p]));
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        next_random_request(req);
        send_request(req, -1, blank, blank);
      end
    end

    wait_quiet();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
